@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command codes and controller/datapath types of the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROWS          = 25;
    localparam int COLUMNS       = 80;
    localparam int CELL_COUNT    = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int COLOR_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam func_t FUNC_PUT     = 3'd0;
    localparam func_t FUNC_NEWLINE = 3'd1;
    localparam func_t FUNC_CLEAR   = 3'd2;
    localparam func_t FUNC_GOTO    = 3'd3;
    localparam func_t FUNC_READ    = 3'd4;

    localparam cfg_idx_t CFG_FG_COLOR   = 2'd0;
    localparam cfg_idx_t CFG_BG_COLOR   = 2'd1;
    localparam cfg_idx_t CFG_BLANK_CHAR = 2'd2;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_HOME,
        CUR_GOTO
    } cur_op_t;

    typedef struct packed {
        logic    capture;
        logic    put_write;
        logic    read_cell;
        logic    sweep_clr;
        logic    copy_step;
        logic    fill;
        logic    fill_blank;
        logic    res_load;
        cur_op_t cur_op;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  scroll_need;
        logic  copy_last;
        logic  fill_last;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
    endfunction

endpackage

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, color registers, sweep pointer for scroll and
// clear, and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [FUNC_W-1:0]     func,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      row,
    input  logic [COL_W-1:0]      column,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attr,
    output logic [ROW_W-1:0]      cursor_row,
    output logic [COL_W-1:0]      cursor_column
);

    logic [CELL_W-1:0] cell_mem [CELL_COUNT];

    func_t             func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;

    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic [CHAR_W-1:0]  blank_reg;

    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              copy_vld_reg;
    logic [ADDR_W-1:0] copy_dst_reg;
    logic [CELL_W-1:0] rd_data_reg;

    logic [CHAR_W-1:0] res_char_reg;
    logic [ATTR_W-1:0] res_attr_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic [COL_W-1:0]  res_col_reg;

    logic [ATTR_W-1:0] attr;
    logic [ROW_W-1:0]  row_clamp;
    logic [COL_W-1:0]  col_clamp;
    logic [ROW_W-1:0]  row_step;
    logic              fill_go;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign attr      = {bg_reg, fg_reg};
    assign row_clamp = (row_reg > ROW_LAST) ? ROW_LAST : row_reg;
    assign col_clamp = (col_reg > COL_LAST) ? COL_LAST : col_reg;
    assign row_step  = (cur_row_reg == ROW_LAST) ? cur_row_reg : cur_row_reg + 1'b1;
    assign fill_go   = cmd.fill && !copy_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            char_reg <= char_code;
            row_reg  <= row;
            col_reg  <= column;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg    <= COLOR_W'(7);
            bg_reg    <= '0;
            blank_reg <= CHAR_W'(32);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FG_COLOR:   fg_reg    <= cfg_data[COLOR_W-1:0];
                CFG_BG_COLOR:   bg_reg    <= cfg_data[COLOR_W-1:0];
                CFG_BLANK_CHAR: blank_reg <= cfg_data[CHAR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        unique case (cmd.cur_op)
            CUR_HOLD: ;
            CUR_ADVANCE:
            begin
                if (cur_col_reg == COL_LAST)
                begin
                    cur_col_next = '0;
                    cur_row_next = row_step;
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
            CUR_NEWLINE:
            begin
                cur_col_next = '0;
                cur_row_next = row_step;
            end
            CUR_HOME:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            CUR_GOTO:
            begin
                cur_col_next = col_clamp;
                cur_row_next = row_clamp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.sweep_clr)
            ptr_next = '0;
        else if (status.fill_last)
            ptr_next = '0;
        else if (cmd.copy_step || fill_go)
            ptr_next = ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            copy_vld_reg <= 1'b0;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            copy_vld_reg <= cmd.copy_step;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= ptr_reg;
    end

    // write port: pending copy first, then fill, then character put
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = cell_addr(cur_row_reg, cur_col_reg);
        wr_data = {attr, char_reg};
        if (copy_vld_reg)
        begin
            mem_we  = 1'b1;
            wr_addr = copy_dst_reg;
            wr_data = rd_data_reg;
        end
        else if (fill_go)
        begin
            mem_we  = 1'b1;
            wr_addr = ptr_reg;
            wr_data = cmd.fill_blank ? {attr, blank_reg} : '0;
        end
        else if (cmd.put_write)
        begin
            mem_we = 1'b1;
        end
    end

    assign rd_en   = cmd.copy_step || cmd.read_cell;
    assign rd_addr = cmd.copy_step ? ptr_reg + ADDR_W'(COLUMNS)
                                   : cell_addr(row_clamp, col_clamp);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            if (func_reg == FUNC_READ)
            begin
                res_char_reg <= rd_data_reg[CHAR_W-1:0];
                res_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
            end
            else
            begin
                res_char_reg <= '0;
                res_attr_reg <= '0;
            end
            res_row_reg <= cur_row_next;
            res_col_reg <= cur_col_next;
        end
    end

    assign status.func        = func_reg;
    assign status.scroll_need = (cur_row_reg == ROW_LAST) &&
                                ((func_reg == FUNC_NEWLINE) ||
                                 ((func_reg == FUNC_PUT) && (cur_col_reg == COL_LAST)));
    assign status.copy_last   = (ptr_reg == ADDR_W'(LAST_ROW_BASE - 1));
    assign status.fill_last   = fill_go && (ptr_reg == ADDR_W'(CELL_COUNT - 1));

    assign cell_char     = res_char_reg;
    assign cell_attr     = res_attr_reg;
    assign cursor_row    = res_row_reg;
    assign cursor_column = res_col_reg;

endmodule

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: accepts words, steps the datapath through put, scroll,
// clear and read, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_COPY  = 7'b0001000,
        ST_ZERO  = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        logic finish;
        finish     = 1'b0;
        state_next = state_reg;
        cmd        = '0;
        cmd.cur_op = CUR_HOLD;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill = 1'b1;
                if (status.fill_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                unique case (status.func)
                    FUNC_PUT:
                    begin
                        cmd.put_write = 1'b1;
                        cmd.cur_op    = CUR_ADVANCE;
                        cmd.sweep_clr = status.scroll_need;
                        if (status.scroll_need)
                            state_next = ST_COPY;
                        else
                            finish = 1'b1;
                    end
                    FUNC_NEWLINE:
                    begin
                        cmd.cur_op    = CUR_NEWLINE;
                        cmd.sweep_clr = status.scroll_need;
                        if (status.scroll_need)
                            state_next = ST_COPY;
                        else
                            finish = 1'b1;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.cur_op    = CUR_HOME;
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    FUNC_GOTO:
                    begin
                        cmd.cur_op = CUR_GOTO;
                        finish     = 1'b1;
                    end
                    FUNC_READ:
                    begin
                        cmd.read_cell = 1'b1;
                        state_next    = ST_RESP;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                if (finish)
                begin
                    cmd.res_load = out_free;
                    state_next   = out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.fill = 1'b1;
                if (status.fill_last)
                    state_next = ST_RESP;
            end
            ST_CLEAR:
            begin
                cmd.fill       = 1'b1;
                cmd.fill_blank = 1'b1;
                if (status.fill_last)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.res_load = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console with cursor, scroll and clear over an
// 80 x 25 screen memory of 16-bit cells.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    func, char_code, row, column
//  out      out_valid / out_ready  cell_char, cell_attr, cursor_row,
//                                  cursor_column
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A scroll makes one copy step per cell of the upper rows through the single
//  memory read port, retires the last copy, then zeroes the bottom row.
//  Clear writes one cell per cycle. After reset the memory is zeroed with
//  in_ready low; cfg writes are taken at any time.
//  A finished result waits in the output register while the next word is
//  taken; a further result holds the sequencer until out_ready.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FUNC_W-1:0]     func,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      row,
    input  logic [COL_W-1:0]      column,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attr,
    output logic [ROW_W-1:0]      cursor_row,
    output logic [COL_W-1:0]      cursor_column,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tcw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .char_code     (char_code),
        .row           (row),
        .column        (column),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column)
    );

endmodule

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] cell_char,
    input logic [ATTR_W-1:0] cell_attr,
    input logic [ROW_W-1:0]  cursor_row,
    input logic [COL_W-1:0]  cursor_column,
    input logic              cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_char) &&
        $stable(cell_attr) && $stable(cursor_row) && $stable(cursor_column))
        else $error("result word changed while stalled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_row <= ROW_LAST) && (cursor_column <= COL_LAST))
        else $error("cursor outside screen");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word taken while previous word in progress");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg port not ready");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_char     (cell_char),
    .cell_attr     (cell_attr),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .cfg_ready     (cfg_ready)
);

@@ tb/text_console_writer_checker.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the command, result and register channels of the text console.
// Keeps its own screen, cursor and color state, works out the report that
// each accepted command word should produce, and compares every result word
// field by field against the oldest pending report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_checker
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [FUNC_W-1:0]     func,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      row,
    input  logic [COL_W-1:0]      column,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CHAR_W-1:0]     cell_char,
    input  logic [ATTR_W-1:0]     cell_attr,
    input  logic [ROW_W-1:0]      cursor_row,
    input  logic [COL_W-1:0]      cursor_column,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } cell_report_t;

    logic [CELL_W-1:0]  screen_model [CELL_COUNT];
    int                 cursor_r;
    int                 cursor_c;
    logic [COLOR_W-1:0] fg_nib;
    logic [COLOR_W-1:0] bg_nib;
    logic [CHAR_W-1:0]  blank_code;
    cell_report_t       report_q [$];
    cell_report_t       want_report;
    cell_report_t       got_report;
    int                 mismatches = 0;
    int                 idx;

    // wrap past the last column, scroll past the last row
    task automatic settle_cursor();
        int k;
        if (cursor_c >= COLUMNS) begin
            cursor_r = cursor_r + 1;
            cursor_c = 0;
        end
        if (cursor_r >= ROWS) begin
            for (k = 0; k < LAST_ROW_BASE; k++)
                screen_model[k] = screen_model[k + COLUMNS];
            for (k = LAST_ROW_BASE; k < CELL_COUNT; k++)
                screen_model[k] = '0;
            cursor_r = ROWS - 1;
        end
    endtask

    task automatic run_console_cmd(
        input  func_t             op,
        input  logic [CHAR_W-1:0] ch,
        input  logic [ROW_W-1:0]  r,
        input  logic [COL_W-1:0]  c,
        output cell_report_t      rep
    );
        int                  rr;
        int                  cc;
        int                  k;
        logic [ATTR_W-1:0]   attr;
        logic [CELL_W-1:0]   cell_word;
        rr   = (r > ROW_LAST) ? ROWS - 1 : int'(r);
        cc   = (c > COL_LAST) ? COLUMNS - 1 : int'(c);
        attr = {bg_nib, fg_nib};
        rep.cell_char = '0;
        rep.cell_attr = '0;
        case (op)
            FUNC_PUT: begin
                screen_model[cursor_r * COLUMNS + cursor_c] = {attr, ch};
                cursor_c = cursor_c + 1;
                settle_cursor();
            end
            FUNC_NEWLINE: begin
                cursor_r = cursor_r + 1;
                cursor_c = 0;
                settle_cursor();
            end
            FUNC_CLEAR: begin
                for (k = 0; k < CELL_COUNT; k++)
                    screen_model[k] = {attr, blank_code};
                cursor_r = 0;
                cursor_c = 0;
            end
            FUNC_GOTO: begin
                cursor_r = rr;
                cursor_c = cc;
            end
            FUNC_READ: begin
                cell_word     = screen_model[rr * COLUMNS + cc];
                rep.cell_char = cell_word[CHAR_W-1:0];
                rep.cell_attr = cell_word[CELL_W-1:CHAR_W];
            end
            default: ;
        endcase
        rep.cursor_row    = ROW_W'(cursor_r);
        rep.cursor_column = COL_W'(cursor_c);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (idx = 0; idx < CELL_COUNT; idx++)
                screen_model[idx] = '0;
            cursor_r   = 0;
            cursor_c   = 0;
            fg_nib     = 4'd7;
            bg_nib     = 4'd0;
            blank_code = 8'd32;
            report_q.delete();
            pending_count <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got_report.cell_char     = cell_char;
                got_report.cell_attr     = cell_attr;
                got_report.cursor_row    = cursor_row;
                got_report.cursor_column = cursor_column;
                if (report_q.size() == 0) begin
                    $error("result word with nothing pending: char %0d attr %0d cursor %0d,%0d",
                           cell_char, cell_attr, cursor_row, cursor_column);
                    mismatches++;
                end else begin
                    want_report = report_q.pop_front();
                    check_field("cell_char", want_report.cell_char, got_report.cell_char);
                    check_field("cell_attr", want_report.cell_attr, got_report.cell_attr);
                    check_field("cursor_row", want_report.cursor_row,
                                got_report.cursor_row);
                    check_field("cursor_column", want_report.cursor_column,
                                got_report.cursor_column);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FG_COLOR:   fg_nib     = cfg_data[COLOR_W-1:0];
                    CFG_BG_COLOR:   bg_nib     = cfg_data[COLOR_W-1:0];
                    CFG_BLANK_CHAR: blank_code = cfg_data[CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                run_console_cmd(func_t'(func), char_code, row, column, want_report);
                report_q.push_back(want_report);
            end
            pending_count <= report_q.size();
        end
        fail_count <= mismatches;
    end

endmodule

@@ tb/text_console_writer_unit_test.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit_test
// Drives the text console with a directed opening (reads at reset, wrap,
// scroll, clamped goto and read, unused codes, clear) and then random
// command sequences over several color settings and idle patterns, with a
// long result stall and drain pauses. Checking is done by the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam func_t FUNC_SPARE_LO = 3'd5;
    localparam func_t FUNC_SPARE_HI = 3'd7;
    localparam int    ROW_SPAN      = 1 << ROW_W;
    localparam int    COL_SPAN      = 1 << COL_W;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    PHASES        = 6;
    localparam int    PHASE_WORDS   = 215;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [FUNC_W-1:0]     func;
    logic [CHAR_W-1:0]     char_code;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;
    logic [ROW_W-1:0]      cursor_row;
    logic [COL_W-1:0]      cursor_column;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int sent_count    = 0;
    int tx_idle_pct   = 24;
    int rx_idle_pct   = 52;
    int hold_request  = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    text_console_writer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .char_code     (char_code),
        .row           (row),
        .column        (column),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    text_console_writer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .char_code     (char_code),
        .row           (row),
        .column        (column),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hold off results for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request != hold_served)
        begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 9) == 0)
            return ROW_W'($urandom_range(0, ROW_SPAN - 1));
        return ROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        if ($urandom_range(0, 9) == 0)
            return COL_W'($urandom_range(0, COL_SPAN - 1));
        return COL_W'($urandom_range(0, COLUMNS - 1));
    endfunction

    task automatic send_cmd(
        input func_t             op,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  r,
        input logic [COL_W-1:0]  c
    );
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= op;
        char_code <= ch;
        row       <= r;
        column    <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_noise_fields(input func_t op);
        send_cmd(op, CHAR_W'($urandom_range(0, 255)),
                 ROW_W'($urandom_range(0, ROW_SPAN - 1)),
                 COL_W'($urandom_range(0, COL_SPAN - 1)));
    endtask

    // hold the command channel until every pending report has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic set_colors(
        input logic [CFG_DATA_W-1:0] fg,
        input logic [CFG_DATA_W-1:0] bg,
        input logic [CFG_DATA_W-1:0] blank
    );
        cfg_idx_t              regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int                    k;
        regs = '{CFG_FG_COLOR, CFG_BG_COLOR, CFG_BLANK_CHAR};
        vals = '{fg, bg, blank};
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int words);
        int target;
        int pick;
        target = sent_count + words;
        while (sent_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_cmd(FUNC_GOTO, CHAR_W'($urandom), pick_row(), pick_col());
                repeat ($urandom_range(1, 12))
                    send_noise_fields(FUNC_PUT);
                if ($urandom_range(0, 2) == 0)
                    send_noise_fields(FUNC_NEWLINE);
            end
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, 4))
                    send_cmd(FUNC_READ, CHAR_W'($urandom), pick_row(), pick_col());
            end
            else if (pick < 80)
            begin
                send_cmd(FUNC_GOTO, CHAR_W'($urandom), ROW_LAST,
                         COL_W'($urandom_range(COLUMNS - 4, COLUMNS - 1)));
                repeat ($urandom_range(2, 6))
                    send_noise_fields(FUNC_PUT);
                send_cmd(FUNC_READ, CHAR_W'($urandom), ROW_W'(ROWS - 2), pick_col());
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(1, 3))
                    send_noise_fields(FUNC_NEWLINE);
            end
            else if (pick < 88)
            begin
                send_noise_fields(FUNC_CLEAR);
            end
            else
            begin
                send_noise_fields(func_t'($urandom_range(0, (1 << FUNC_W) - 1)));
            end
        end
    endtask

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_PUT;
        char_code = '0;
        row       = '0;
        column    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FG_COLOR;
        cfg_data  = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_cmd(FUNC_PUT, 8'h00, 5'd0, 7'd0);
        send_cmd(FUNC_PUT, 8'hFF, ROW_W'(ROW_SPAN - 1), COL_W'(COL_SPAN - 1));
        send_cmd(FUNC_READ, 8'h00, 5'd0, 7'd1);
        send_cmd(FUNC_GOTO, 8'h00, ROW_W'(ROW_SPAN - 1), COL_W'(COL_SPAN - 1));
        send_cmd(FUNC_PUT, 8'h41, 5'd0, 7'd0);
        send_cmd(FUNC_READ, 8'h00, ROW_W'(ROWS - 2), COL_LAST);
        send_cmd(FUNC_READ, 8'h00, ROW_LAST, COL_LAST);
        send_cmd(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0);
        send_cmd(FUNC_READ, 8'h00, ROW_W'(ROWS - 3), COL_LAST);
        send_cmd(FUNC_GOTO, 8'h00, 5'd0, COL_LAST);
        send_cmd(FUNC_PUT, 8'h7E, 5'd0, 7'd0);
        send_cmd(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0);
        send_cmd(FUNC_READ, 8'h00, ROW_W'(ROW_SPAN - 1), COL_W'(COL_SPAN - 1));
        send_cmd(FUNC_SPARE_LO, 8'h55, 5'd10, 7'd20);
        send_cmd(FUNC_SPARE_HI, 8'hFF, ROW_W'(ROW_SPAN - 1), COL_W'(COL_SPAN - 1));
        send_cmd(FUNC_CLEAR, 8'h00, 5'd0, 7'd0);
        send_cmd(FUNC_READ, 8'h00, 5'd12, 7'd40);
        send_cmd(FUNC_GOTO, 8'h00, ROW_LAST, 7'd0);
        send_cmd(FUNC_PUT, 8'h80, 5'd0, 7'd0);
        send_cmd(FUNC_READ, 8'h00, ROW_LAST, 7'd0);
        send_cmd(FUNC_GOTO, 8'h00, 5'd0, 7'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase < 2)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 52;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 52;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: set_colors(8'hFF, 8'hFF, 8'hFF);
                1: set_colors(8'h00, 8'h00, 8'h00);
                default: set_colors(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom));
            endcase
            send_noise_fields(FUNC_CLEAR);
            if (phase == 1)
            begin
                run_random(PHASE_WORDS / 2);
                hold_request <= hold_request + 1;
                run_random(PHASE_WORDS / 2);
            end
            else
            begin
                run_random(PHASE_WORDS);
            end
        end

        drain();
        repeat (50)
            @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
